/* rtl/core/uiarc_pkg.sv */
// shared types and constants for the udp/ipv4/arp receive classifier
// no dependencies
package uiarc_pkg;

    localparam int MaxFrameBytesDefault = 2048;

    localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
    localparam logic [15:0] ETYPE_ARP   = 16'h0806;
    localparam logic [15:0] FRAG_MASK   = 16'h3FFF;
    localparam logic [7:0]  IHL_MASK    = 8'h0F;
    localparam logic [15:0] WORD_MASK   = 16'hFFFF;
    localparam logic [7:0]  PROTO_UDP   = 8'd17;
    localparam logic [47:0] BCAST_MAC   = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] IP_ALL_ONES = 32'hFFFF_FFFF;

    localparam logic [2:0] CFG_OWN_MAC    = 3'd0;
    localparam logic [2:0] CFG_OWN_IP     = 3'd1;
    localparam logic [2:0] CFG_OWN_PORT   = 3'd2;
    localparam logic [2:0] CFG_RX_BUF     = 3'd3;
    localparam logic [2:0] CFG_VERIFY_SUM = 3'd4;

    localparam logic [1:0] VERDICT_DROP = 2'd0;
    localparam logic [1:0] VERDICT_UDP  = 2'd1;
    localparam logic [1:0] VERDICT_ARP  = 2'd2;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } in_item_t;

    typedef struct packed {
        logic        out_kind;
        logic [7:0]  payload_byte;
        logic [1:0]  verdict;
        logic [10:0] payload_length;
        logic [31:0] source_ip;
        logic [15:0] source_port;
        logic [47:0] sender_mac;
        logic [47:0] learned_peer_mac;
        logic        peer_known;
        logic        result_last;
    } out_item_t;

    // one queue entry: everything a single byte produces
    typedef struct packed {
        logic        emit;
        logic [7:0]  pbyte;
        logic        fin;
        logic [1:0]  verdict;
        logic [10:0] plen;
        logic [31:0] sip;
        logic [15:0] sport;
        logic [47:0] smac;
        logic [47:0] prev_peer_addr;
        logic        prev_peer_known;
        logic [47:0] peer_addr;
        logic        peer_known;
    } cls_t;

endpackage

/* rtl/core/uiarc_parser.sv */
// front part: parses one frame byte a cycle while take is high and classifies it
// depends on uiarc_pkg
module uiarc_parser #(
    parameter int MAX_FRAME_BYTES = uiarc_pkg::MaxFrameBytesDefault
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               take,
    input  uiarc_pkg::in_item_t item,
    input  logic [47:0]        own_mac,
    input  logic [31:0]        own_ip,
    input  logic [15:0]        own_udp_port,
    input  logic [10:0]        rx_buffer_size,
    input  logic               verify_ip_checksum,
    output uiarc_pkg::cls_t    cls
);
    import uiarc_pkg::*;

    localparam int IW = $clog2(MAX_FRAME_BYTES + 1);

    logic [IW-1:0] idx_reg, idx_next;
    logic [47:0] dmac_reg, dmac_next, smac_reg, smac_next;
    logic [15:0] etype_reg, etype_next;
    logic [3:0]  ihl_reg, ihl_next;
    logic [15:0] tlen_reg, tlen_next;
    logic [31:0] ipsrc_reg, ipsrc_next, ipdst_reg, ipdst_next;
    logic [16:0] sum_reg, sum_next;
    logic [47:0] udp_reg, udp_next;
    logic [47:0] arp0_reg, arp0_next;
    logic [63:0] arp1_reg, arp1_next;
    logic        drop_reg, drop_next;
    logic [47:0] peer_reg, peer_next;
    logic        pvalid_reg, pvalid_next;

    logic [7:0]  b;
    logic [IW-1:0] p;
    logic        in_range;
    logic [IW:0] len;
    logic [IW-1:0] a, i;
    logic [5:0]  hdr;
    logic [IW-1:0] u;
    logic [16:0] sum_add;
    logic [15:0] ulen, ulen_new;
    logic [16:0] tot_minus_hdr;
    logic        emit;
    logic [7:0]  arp_exp;

    always_comb begin
        b = item.rx_byte;
        p = idx_reg;
        in_range = (idx_reg < IW'(MAX_FRAME_BYTES));
        idx_next = idx_reg; dmac_next = dmac_reg; smac_next = smac_reg;
        etype_next = etype_reg; ihl_next = ihl_reg; tlen_next = tlen_reg;
        ipsrc_next = ipsrc_reg; ipdst_next = ipdst_reg; sum_next = sum_reg;
        udp_next = udp_reg; arp0_next = arp0_reg; arp1_next = arp1_reg;
        drop_next = drop_reg; peer_next = peer_reg; pvalid_next = pvalid_reg;
        emit = 1'b0;
        len = '0;
        a = p - IW'(14);
        i = a;
        hdr = {ihl_reg, 2'b00};
        u = '0;
        sum_add = '0;
        ulen = udp_reg[15:0];
        ulen_new = '0;
        tot_minus_hdr = '0;
        arp_exp = 8'h00;
        case (a[2:0])
            3'd1: arp_exp = 8'h01;
            3'd2: arp_exp = 8'h08;
            3'd4: arp_exp = 8'h06;
            3'd5: arp_exp = 8'h04;
            3'd7: arp_exp = 8'h01;
            default: arp_exp = 8'h00;
        endcase
        cls = '0;

        if (!in_range) begin
            drop_next = 1'b1;
        end else begin
            idx_next = idx_reg + 1'b1;
            len = {1'b0, p} + 1'b1;
            if (p < IW'(6)) begin
                dmac_next = {dmac_reg[39:0], b};
            end else if (p < IW'(12)) begin
                smac_next = {smac_reg[39:0], b};
            end else if (p < IW'(14)) begin
                etype_next = {etype_reg[7:0], b};
                if (p == IW'(13)) begin
                    if (etype_next == ETYPE_IPV4) begin
                        if (dmac_reg != own_mac && dmac_reg != BCAST_MAC) drop_next = 1'b1;
                    end else if (etype_next != ETYPE_ARP) begin
                        drop_next = 1'b1;
                    end
                end
            end else if (!drop_reg) begin
                if (etype_reg == ETYPE_ARP) begin
                    if (a < IW'(8)) begin
                        if (b != arp_exp) drop_next = 1'b1;
                    end else if (a < IW'(14)) begin
                        arp0_next = {arp0_reg[39:0], b};
                    end else if (a < IW'(18) || (a >= IW'(24) && a < IW'(28))) begin
                        arp1_next = {arp1_reg[55:0], b};
                    end
                end else begin
                    if (i == '0) begin
                        hdr = {b[3:0], 2'b00};
                        if (b[7:4] != 4'd4 || b[3:0] < 4'd5) begin
                            drop_next = 1'b1;
                        end else begin
                            ihl_next = b[3:0] & IHL_MASK[3:0];
                        end
                    end
                    if (!(i == '0 && (b[7:4] != 4'd4 || b[3:0] < 4'd5))) begin
                        if (i < IW'(hdr)) begin
                            sum_add = {1'b0, sum_reg[15:0]}
                                + (i[0] ? {9'd0, b} : {1'b0, b, 8'd0});
                            sum_next = sum_add[16] ? {1'b0, sum_add[15:0] + 16'd1} : sum_add;
                            if (i == IW'(2) || i == IW'(3)) tlen_next = {tlen_reg[7:0], b};
                            if (i == IW'(3) && tlen_next < 16'(hdr) + 16'd8)
                                drop_next = 1'b1;
                            if (i == IW'(6) && (b & FRAG_MASK[15:8]) != 8'd0) drop_next = 1'b1;
                            if (i == IW'(7) && (b & FRAG_MASK[7:0]) != 8'd0) drop_next = 1'b1;
                            if (i == IW'(9) && b != PROTO_UDP) drop_next = 1'b1;
                            if (i >= IW'(12) && i < IW'(16)) ipsrc_next = {ipsrc_reg[23:0], b};
                            if (i >= IW'(16) && i < IW'(20)) ipdst_next = {ipdst_reg[23:0], b};
                            if (i == IW'(19) && ipdst_next != own_ip
                                && ipdst_next != IP_ALL_ONES)
                                drop_next = 1'b1;
                            if (i + 1'b1 == IW'(hdr) && verify_ip_checksum
                                && sum_next[15:0] != WORD_MASK)
                                drop_next = 1'b1;
                        end else begin
                            u = i - IW'(hdr);
                            if (u < IW'(6)) begin
                                udp_next = {udp_reg[39:0], b};
                                ulen_new = udp_next[15:0];
                                if (u == IW'(3) && ulen_new != own_udp_port) drop_next = 1'b1;
                                if (u == IW'(5)) begin
                                    tot_minus_hdr = {1'b0, tlen_reg} - 17'(hdr);
                                    if (ulen_new < 16'd8
                                        || (tot_minus_hdr[16] == 1'b0
                                            && {1'b0, ulen_new} > tot_minus_hdr)
                                        || (ulen_new - 16'd8) > {5'd0, rx_buffer_size})
                                        drop_next = 1'b1;
                                end
                            end else begin
                                emit = u >= IW'(8) && 32'(u) < 32'(ulen);
                            end
                        end
                    end
                end
            end
        end

        cls.emit = emit;
        cls.pbyte = b;
        cls.fin = item.frame_end;
        if (item.frame_end) begin
            if (!drop_next && len >= (IW+1)'(14)) begin
                if (etype_next == ETYPE_ARP) begin
                    if (len >= (IW+1)'(42) && arp1_next[31:0] == own_ip) begin
                        cls.verdict = VERDICT_ARP;
                        cls.sip = arp1_next[63:32];
                        cls.smac = arp0_next;
                    end
                end else if (etype_next == ETYPE_IPV4) begin
                    if (len >= (IW+1)'(34)
                        && 17'(tlen_next) + 17'd14 <= 17'(len)) begin
                        cls.verdict = VERDICT_UDP;
                        cls.plen = 11'(udp_next[15:0] - 16'd8);
                        cls.sip = ipsrc_next;
                        cls.sport = udp_next[47:32];
                        if (dmac_next != BCAST_MAC) begin
                            peer_next = smac_next;
                            pvalid_next = 1'b1;
                        end
                    end
                end
            end
        end
        // a payload beat shows the peer as it was before this byte's verdict
        cls.prev_peer_addr = peer_reg;
        cls.prev_peer_known = pvalid_reg;
        cls.peer_addr = peer_next;
        cls.peer_known = pvalid_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (take && item.frame_end)) begin
            idx_reg <= '0; dmac_reg <= '0; smac_reg <= '0; etype_reg <= '0;
            ihl_reg <= '0; tlen_reg <= '0; ipsrc_reg <= '0; ipdst_reg <= '0;
            sum_reg <= '0; udp_reg <= '0; arp0_reg <= '0; arp1_reg <= '0;
            drop_reg <= 1'b0;
        end else if (take) begin
            idx_reg <= idx_next; dmac_reg <= dmac_next; smac_reg <= smac_next;
            etype_reg <= etype_next; ihl_reg <= ihl_next; tlen_reg <= tlen_next;
            ipsrc_reg <= ipsrc_next; ipdst_reg <= ipdst_next; sum_reg <= sum_next;
            udp_reg <= udp_next; arp0_reg <= arp0_next; arp1_reg <= arp1_next;
            drop_reg <= drop_next;
        end
        if (!aresetn) begin
            peer_reg <= '0;
            pvalid_reg <= 1'b0;
        end else if (take) begin
            peer_reg <= peer_next;
            pvalid_reg <= pvalid_next;
        end
    end

endmodule

/* rtl/core/uiarc_queue.sv */
// short fifo between the parser and the result sequencer
// depends on uiarc_pkg
module uiarc_queue #(
    parameter int DEPTH = 4
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_en,
    input  uiarc_pkg::cls_t wr_data,
    output logic            full,
    input  logic            rd_en,
    output uiarc_pkg::cls_t rd_data,
    output logic            empty
);
    import uiarc_pkg::*;

    localparam int AW = $clog2(DEPTH);

    cls_t mem [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;

    assign full = cnt_reg == (AW+1)'(DEPTH);
    assign empty = cnt_reg == '0;
    assign rd_data = mem[rp_reg];

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wp_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr_en) wp_reg <= wp_reg + 1'b1;
            if (rd_en) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end

endmodule

/* rtl/core/uiarc_emitter.sv */
// back part: turns one queue entry into its payload beat, its verdict beat or both, or pops it with no beat
// depends on uiarc_pkg
module uiarc_emitter (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_empty,
    input  uiarc_pkg::cls_t     q_data,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output uiarc_pkg::out_item_t m_data
);
    import uiarc_pkg::*;

    logic      sent_payload_reg;
    out_item_t beat;
    logic      has_any;
    logic      on_payload;

    always_comb begin
        has_any = q_data.emit || q_data.fin;
        on_payload = q_data.emit && !sent_payload_reg;
        beat = '0;
        if (on_payload) begin
            beat.out_kind = KIND_PAYLOAD;
            beat.payload_byte = q_data.pbyte;
            beat.learned_peer_mac = q_data.prev_peer_addr;
            beat.peer_known = q_data.prev_peer_known;
            beat.result_last = !q_data.fin;
        end else begin
            beat.out_kind = KIND_VERDICT;
            beat.verdict = q_data.verdict;
            beat.payload_length = q_data.plen;
            beat.source_ip = q_data.sip;
            beat.source_port = q_data.sport;
            beat.sender_mac = q_data.smac;
            beat.learned_peer_mac = q_data.peer_addr;
            beat.peer_known = q_data.peer_known;
            beat.result_last = 1'b1;
        end
        m_valid = !q_empty && has_any;
        m_data = beat;
        q_pop = !q_empty && (!has_any || (m_ready && beat.result_last));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sent_payload_reg <= 1'b0;
        end else if (q_pop) begin
            sent_payload_reg <= 1'b0;
        end else if (m_valid && m_ready && on_payload) begin
            sent_payload_reg <= 1'b1;
        end
    end

endmodule

/* rtl/core/udp_ipv4_arp_rx_classifier.sv */
// top level of the udp/ipv4/arp receive classifier
// depends on uiarc_pkg, uiarc_parser, uiarc_queue, uiarc_emitter
//
// s_ channel: one frame byte per beat, s_data.frame_end on the last byte.
// m_ channel: result beats; a udp payload byte (out_kind 0) as it arrives,
// and one verdict beat (out_kind 1) after the last byte of each frame.
// cfg_we/cfg_index/cfg_data write own mac, own ip, own port, buffer size and
// the checksum enable; write only while no frame is in flight.
// the parser takes a byte every cycle while s_ready is high and classifies it
// in the same cycle; its result goes into a four-entry queue read by the result
// sequencer, and results reach the m_ side from the queue head.
// throughput: one byte per cycle while s_ready is high; a byte that ends a
// frame and also carries payload needs two output beats, which the queue absorbs.
// a stalled m_ side fills the queue, then s_ready drops.
// reset (aresetn low, synchronous) clears frame state, the learned peer and
// the queue; configuration goes back to its reset values.
module udp_ipv4_arp_rx_classifier #(
    parameter int MAX_FRAME_BYTES = uiarc_pkg::MaxFrameBytesDefault
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  uiarc_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output uiarc_pkg::out_item_t m_data,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [47:0]          cfg_data
);
    import uiarc_pkg::*;

    logic [47:0] own_mac_reg;
    logic [31:0] own_ip_reg;
    logic [15:0] own_port_reg;
    logic [10:0] rx_buf_reg;
    logic        verify_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_mac_reg <= '0;
            own_ip_reg <= '0;
            own_port_reg <= '0;
            rx_buf_reg <= 11'd1472;
            verify_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_OWN_MAC:    own_mac_reg <= cfg_data;
                CFG_OWN_IP:     own_ip_reg <= cfg_data[31:0];
                CFG_OWN_PORT:   own_port_reg <= cfg_data[15:0];
                CFG_RX_BUF:     rx_buf_reg <= cfg_data[10:0];
                CFG_VERIFY_SUM: verify_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic take, q_full, q_empty, q_pop;
    cls_t cls, q_data;

    assign s_ready = !q_full;
    assign take = s_valid && s_ready;

    uiarc_parser #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_parser (
        .aclk, .aresetn, .take, .item(s_data),
        .own_mac(own_mac_reg), .own_ip(own_ip_reg), .own_udp_port(own_port_reg),
        .rx_buffer_size(rx_buf_reg), .verify_ip_checksum(verify_reg), .cls
    );

    uiarc_queue #(.DEPTH(4)) u_queue (
        .aclk, .aresetn, .wr_en(take), .wr_data(cls), .full(q_full),
        .rd_en(q_pop), .rd_data(q_data), .empty(q_empty)
    );

    uiarc_emitter u_emitter (
        .aclk, .aresetn, .q_empty, .q_data, .q_pop,
        .m_valid, .m_ready, .m_data
    );

    // a verdict beat always closes the result group of its byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.out_kind == KIND_VERDICT |-> m_data.result_last)
        else $error("verdict beat without result_last");

    // the queue never takes a byte while full
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !take)
        else $error("queue overrun");

    // a payload beat never carries a verdict
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.out_kind == KIND_PAYLOAD |-> m_data.verdict == VERDICT_DROP)
        else $error("payload beat carries verdict");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// self-checking bench for the udp/ipv4/arp receive classifier: random frames,
// an in-bench frame classifier as predictor, random idling on both sides
// depends on uiarc_pkg and udp_ipv4_arp_rx_classifier
module testbench;
    import uiarc_pkg::*;

    localparam int FRAME_CAP = 256;
    localparam int QUIET_LIMIT = 4000;
    localparam int PHASE_BYTES = 200;
    localparam logic [63:0] ARP_FIXED = 64'h0001_0800_0604_0001;

    typedef struct {
        logic [7:0] b;
        logic       fin;
        bit         typed;
    } stim_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [47:0] cfg_data;

    udp_ipv4_arp_rx_classifier #(.MAX_FRAME_BYTES(FRAME_CAP)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // register copies
    logic [47:0] own_mac;
    logic [31:0] own_ip;
    logic [15:0] own_port;
    logic [10:0] rx_buf;
    logic        verify_sum;

    // frame parse state
    int          fr_pos;
    logic [47:0] fr_dmac, fr_smac;
    logic [15:0] fr_etype;
    logic [3:0]  fr_ihl;
    int          fr_total;
    logic [7:0]  fr_proto;
    logic [31:0] fr_ip_src, fr_ip_dst;
    int          fr_hsum;
    logic [47:0] fr_udp;
    logic [47:0] fr_arp_mac;
    logic [63:0] fr_arp_ips;
    bit          fr_dropped;
    logic [47:0] peer_addr;
    logic        peer_ok;

    out_item_t expected_q[$];
    logic [7:0] frame_q[$];

    int  accepted, taken, failures, quiet;
    int  frames_sent, udp_accepts, arp_hits, drops;
    bit  steady, typed_now;
    out_item_t typed_drop;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    task automatic clear_frame();
        fr_pos = 0; fr_dmac = '0; fr_smac = '0; fr_etype = '0; fr_ihl = '0;
        fr_total = 0; fr_proto = '0; fr_ip_src = '0; fr_ip_dst = '0; fr_hsum = 0;
        fr_udp = '0; fr_arp_mac = '0; fr_arp_ips = '0; fr_dropped = 0;
    endtask

    function automatic bit parse_ipv4(int i, logic [7:0] b);
        int hdr, u, ulen;
        hdr = int'(fr_ihl) * 4;
        if (i == 0) begin
            if (b[7:4] != 4'd4 || b[3:0] < 4'd5) begin
                fr_dropped = 1;
                return 0;
            end
            fr_ihl = b[3:0];
            hdr = int'(fr_ihl) * 4;
        end
        if (i < hdr) begin
            fr_hsum += (i % 2) ? int'(b) : int'(b) << 8;
            if (fr_hsum > 16'hFFFF) fr_hsum = (fr_hsum & 16'hFFFF) + 1;
            if (i == 2 || i == 3) fr_total = ((fr_total << 8) | int'(b)) & 16'hFFFF;
            if (i == 3 && fr_total < hdr + 8) fr_dropped = 1;
            if (i == 6 && (b & FRAG_MASK[15:8]) != 0) fr_dropped = 1;
            if (i == 7 && (b & FRAG_MASK[7:0]) != 0) fr_dropped = 1;
            if (i == 9) begin
                fr_proto = b;
                if (b != PROTO_UDP) fr_dropped = 1;
            end
            if (i >= 12 && i < 16) fr_ip_src = {fr_ip_src[23:0], b};
            if (i >= 16 && i < 20) fr_ip_dst = {fr_ip_dst[23:0], b};
            if (i == 19 && fr_ip_dst != own_ip && fr_ip_dst != IP_ALL_ONES) fr_dropped = 1;
            if (i + 1 == hdr && verify_sum && fr_hsum != 16'hFFFF) fr_dropped = 1;
            return 0;
        end
        u = i - hdr;
        ulen = int'(fr_udp[15:0]);
        if (u < 6) begin
            fr_udp = {fr_udp[39:0], b};
            if (u == 3 && fr_udp[15:0] != own_port) fr_dropped = 1;
            if (u == 5) begin
                ulen = int'(fr_udp[15:0]);
                if (ulen < 8 || ulen > fr_total - hdr || ulen - 8 > int'(rx_buf))
                    fr_dropped = 1;
            end
            return 0;
        end
        return !fr_dropped && u >= 8 && u < ulen;
    endfunction

    function automatic bit parse_byte(int p, logic [7:0] b);
        int a;
        if (p < 6) begin
            fr_dmac = {fr_dmac[39:0], b};
            return 0;
        end
        if (p < 12) begin
            fr_smac = {fr_smac[39:0], b};
            return 0;
        end
        if (p < 14) begin
            fr_etype = {fr_etype[7:0], b};
            if (p == 13) begin
                if (fr_etype == ETYPE_IPV4) begin
                    if (fr_dmac != own_mac && fr_dmac != BCAST_MAC) fr_dropped = 1;
                end else if (fr_etype != ETYPE_ARP) begin
                    fr_dropped = 1;
                end
            end
            return 0;
        end
        if (fr_dropped) return 0;
        if (fr_etype == ETYPE_ARP) begin
            a = p - 14;
            if (a < 8) begin
                if (b != ARP_FIXED[63 - 8 * a -: 8]) fr_dropped = 1;
            end else if (a < 14) begin
                fr_arp_mac = {fr_arp_mac[39:0], b};
            end else if (a < 18 || (a >= 24 && a < 28)) begin
                fr_arp_ips = {fr_arp_ips[55:0], b};
            end
            return 0;
        end
        return parse_ipv4(p - 14, b);
    endfunction

    // works out the results of one frame byte and queues them
    task automatic classify_byte(logic [7:0] b, logic fin);
        out_item_t r;
        int len;
        bit emit;
        len = 0;
        emit = 0;
        if (fr_pos >= FRAME_CAP) begin
            fr_dropped = 1;
        end else begin
            emit = parse_byte(fr_pos, b);
            fr_pos++;
            len = fr_pos;
        end
        if (emit) begin
            r = '0;
            r.out_kind = KIND_PAYLOAD;
            r.payload_byte = b;
            r.learned_peer_mac = peer_addr;
            r.peer_known = peer_ok;
            expected_q.push_back(r);
        end
        if (fin) begin
            r = '0;
            r.out_kind = KIND_VERDICT;
            r.verdict = VERDICT_DROP;
            if (!fr_dropped && len >= 14) begin
                if (fr_etype == ETYPE_ARP) begin
                    if (len >= 42 && fr_arp_ips[31:0] == own_ip) begin
                        r.verdict = VERDICT_ARP;
                        r.source_ip = fr_arp_ips[63:32];
                        r.sender_mac = fr_arp_mac;
                    end
                end else if (fr_etype == ETYPE_IPV4) begin
                    if (len >= 34 && 14 + fr_total <= len) begin
                        r.verdict = VERDICT_UDP;
                        r.payload_length = 11'(fr_udp[15:0] - 16'd8);
                        r.source_ip = fr_ip_src;
                        r.source_port = fr_udp[47:32];
                        if (fr_dmac != BCAST_MAC) begin
                            peer_addr = fr_smac;
                            peer_ok = 1'b1;
                        end
                    end
                end
            end
            r.learned_peer_mac = peer_addr;
            r.peer_known = peer_ok;
            expected_q.push_back(r);
            clear_frame();
        end
        if (emit || fin) expected_q[$].result_last = 1'b1;
    endtask

    task automatic compare_result(out_item_t got, out_item_t want);
        if (got.out_kind !== want.out_kind) begin
            $error("out_kind: expected %0h, got %0h", want.out_kind, got.out_kind);
            failures++;
        end
        if (got.payload_byte !== want.payload_byte) begin
            $error("payload_byte: expected %0h, got %0h", want.payload_byte, got.payload_byte);
            failures++;
        end
        if (got.verdict !== want.verdict) begin
            $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
            failures++;
        end
        if (got.payload_length !== want.payload_length) begin
            $error("payload_length: expected %0d, got %0d",
                   want.payload_length, got.payload_length);
            failures++;
        end
        if (got.source_ip !== want.source_ip) begin
            $error("source_ip: expected %0h, got %0h", want.source_ip, got.source_ip);
            failures++;
        end
        if (got.source_port !== want.source_port) begin
            $error("source_port: expected %0h, got %0h", want.source_port, got.source_port);
            failures++;
        end
        if (got.sender_mac !== want.sender_mac) begin
            $error("sender_mac: expected %0h, got %0h", want.sender_mac, got.sender_mac);
            failures++;
        end
        if (got.learned_peer_mac !== want.learned_peer_mac) begin
            $error("learned_peer_mac: expected %0h, got %0h",
                   want.learned_peer_mac, got.learned_peer_mac);
            failures++;
        end
        if (got.peer_known !== want.peer_known) begin
            $error("peer_known: expected %0b, got %0b", want.peer_known, got.peer_known);
            failures++;
        end
        if (got.result_last !== want.result_last) begin
            $error("result_last: expected %0b, got %0b", want.result_last, got.result_last);
            failures++;
        end
    endtask

    // beat accounting, prediction, checking and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                taken++;
                if (expected_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    failures++;
                end else begin
                    if (expected_q[0].out_kind == KIND_VERDICT) begin
                        case (expected_q[0].verdict)
                            VERDICT_UDP: udp_accepts++;
                            VERDICT_ARP: arp_hits++;
                            default: drops++;
                        endcase
                    end
                    compare_result(m_data, expected_q.pop_front());
                end
            end
            if (s_valid && s_ready) begin
                accepted++;
                classify_byte(s_data.rx_byte, s_data.frame_end);
                if (typed_now) expected_q[$] = typed_drop;
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", quiet);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // result side: random stalls per beat
    initial begin
        int stall, target;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            target = taken + 1;
            do @(negedge aclk); while (taken < target);
        end
    end

    task automatic send_byte(logic [7:0] b, logic fin);
        int gap, target;
        gap = steady ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data.rx_byte = b;
        s_data.frame_end = fin;
        s_valid = 1'b1;
        target = accepted + 1;
        do @(negedge aclk); while (accepted < target);
    endtask

    task automatic send_frame();
        foreach (frame_q[k]) send_byte(frame_q[k], k == frame_q.size() - 1);
        frames_sent++;
    endtask

    task automatic settle();
        s_valid = 1'b0;
        do @(negedge aclk); while (expected_q.size() != 0);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [47:0] value);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge aclk);
        cfg_we = 1'b0;
        case (idx)
            CFG_OWN_MAC:    own_mac = value;
            CFG_OWN_IP:     own_ip = value[31:0];
            CFG_OWN_PORT:   own_port = value[15:0];
            CFG_RX_BUF:     rx_buf = value[10:0];
            CFG_VERIFY_SUM: verify_sum = value[0];
            default: ;
        endcase
    endtask

    task automatic push_bytes(logic [47:0] v, int n);
        for (int k = n - 1; k >= 0; k--) frame_q.push_back(v[8 * k +: 8]);
    endtask

    function automatic logic [47:0] rand48();
        return 48'({$urandom, $urandom});
    endfunction

    // truncation, padding or a flipped byte on some frames
    task automatic damage();
        int r, n, pos;
        r = $urandom_range(0, 9);
        if (r == 0 && frame_q.size() > 1) begin
            n = $urandom_range(1, 10);
            while (n > 0 && frame_q.size() > 1) begin
                void'(frame_q.pop_back());
                n--;
            end
        end else if (r == 1) begin
            repeat ($urandom_range(1, 10)) frame_q.push_back(8'($urandom_range(0, 255)));
        end else if (r == 2) begin
            pos = $urandom_range(0, frame_q.size() - 1);
            frame_q[pos] = frame_q[pos] ^ 8'($urandom_range(1, 255));
        end
    endtask

    task automatic build_udp();
        int r, ihl, pay, ulen, tot, h, sum;
        logic [15:0] cks;
        frame_q.delete();
        r = $urandom_range(0, 9);
        push_bytes(r < 6 ? own_mac : (r < 8 ? BCAST_MAC : rand48()), 6);
        push_bytes(rand48(), 6);
        push_bytes(48'(ETYPE_IPV4), 2);
        ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5;
        pay = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 150) : $urandom_range(0, 24);
        ulen = pay + 8;
        tot = ihl * 4 + ulen;
        h = frame_q.size();
        frame_q.push_back({4'h4, 4'(ihl)});
        frame_q.push_back(8'($urandom_range(0, 255)));
        push_bytes(48'(tot), 2);
        push_bytes(48'($urandom_range(0, 65535)), 2);
        r = $urandom_range(0, 9);
        push_bytes(48'(r == 0 ? $urandom_range(0, 65535) : (r < 5 ? 16'h4000 : 16'h0000)), 2);
        frame_q.push_back(8'($urandom_range(0, 255)));
        frame_q.push_back(($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255)) : PROTO_UDP);
        push_bytes(48'(0), 2);
        push_bytes(48'($urandom), 4);
        r = $urandom_range(0, 19);
        push_bytes(48'(r < 14 ? own_ip : (r < 17 ? IP_ALL_ONES : 32'($urandom))), 4);
        repeat ((ihl - 5) * 4) frame_q.push_back(8'($urandom_range(0, 255)));
        sum = 0;
        for (int k = 0; k < ihl * 2; k++)
            sum += int'({frame_q[h + 2 * k], frame_q[h + 2 * k + 1]});
        while (sum > 16'hFFFF) sum = (sum & 16'hFFFF) + (sum >> 16);
        cks = ~sum[15:0];
        if ($urandom_range(0, 9) == 0) cks ^= 16'($urandom_range(1, 65535));
        frame_q[h + 10] = cks[15:8];
        frame_q[h + 11] = cks[7:0];
        push_bytes(48'($urandom_range(0, 65535)), 2);
        push_bytes(($urandom_range(0, 7) == 0) ? 48'($urandom_range(0, 65535)) : 48'(own_port),
                   2);
        push_bytes(48'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 200) : ulen), 2);
        push_bytes(48'($urandom_range(0, 65535)), 2);
        repeat (pay) frame_q.push_back(8'($urandom_range(0, 255)));
        damage();
    endtask

    task automatic build_arp();
        frame_q.delete();
        push_bytes($urandom_range(0, 1) ? BCAST_MAC : rand48(), 6);
        push_bytes(rand48(), 6);
        push_bytes(48'(ETYPE_ARP), 2);
        push_bytes(ARP_FIXED[63:16], 6);
        push_bytes(48'(ARP_FIXED[15:0]), 2);
        push_bytes(rand48(), 6);
        push_bytes(48'($urandom), 4);
        push_bytes(rand48(), 6);
        push_bytes(48'(($urandom_range(0, 3) != 0) ? own_ip : 32'($urandom)), 4);
        if ($urandom_range(0, 1)) while (frame_q.size() < 60) frame_q.push_back(8'h00);
        damage();
    endtask

    task automatic build_noise(int len);
        frame_q.delete();
        repeat (len) frame_q.push_back(8'($urandom_range(0, 255)));
        if (len > 13 && $urandom_range(0, 2) == 0) begin
            frame_q[12] = 8'h81;
            frame_q[13] = 8'h00;
        end
    endtask

    stim_row_t directed_rows[18] = '{
        '{8'h00, 1'b1, 1'b1},
        '{8'hAA, 1'b0, 1'b0}, '{8'h55, 1'b0, 1'b0}, '{8'h80, 1'b1, 1'b1},
        '{8'hFF, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0},
        '{8'h12, 1'b0, 1'b0}, '{8'h34, 1'b0, 1'b0}, '{8'h56, 1'b0, 1'b0},
        '{8'h78, 1'b0, 1'b0}, '{8'h9A, 1'b0, 1'b0}, '{8'hBC, 1'b0, 1'b0},
        '{8'h81, 1'b0, 1'b0}, '{8'h00, 1'b1, 1'b1}
    };

    initial begin
        int phase_start, r;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        own_mac = '0; own_ip = '0; own_port = '0; rx_buf = 11'd1472; verify_sum = 1'b0;
        peer_addr = '0; peer_ok = 1'b0;
        clear_frame();
        accepted = 0; taken = 0; failures = 0; quiet = 0;
        frames_sent = 0; udp_accepts = 0; arp_hits = 0; drops = 0;
        steady = 0; typed_now = 0;
        typed_drop = '0;
        typed_drop.out_kind = KIND_VERDICT;
        typed_drop.verdict = VERDICT_DROP;
        typed_drop.result_last = 1'b1;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        // one-byte frame, short frame, vlan frame under reset settings
        foreach (directed_rows[k]) begin
            typed_now = directed_rows[k].typed;
            send_byte(directed_rows[k].b, directed_rows[k].fin);
        end
        typed_now = 0;

        for (int phase = 0; phase < 6; phase++) begin
            settle();
            case (phase)
                0: ;
                1: begin
                    write_reg(CFG_OWN_MAC, 48'hFFFF_FFFF_FFFF);
                    write_reg(CFG_OWN_IP, 48'hFFFF_FFFF);
                    write_reg(CFG_OWN_PORT, 48'hFFFF);
                    write_reg(CFG_RX_BUF, 48'd2047);
                    write_reg(CFG_VERIFY_SUM, 48'd1);
                end
                2: begin
                    write_reg(CFG_OWN_MAC, rand48());
                    write_reg(CFG_OWN_IP, 48'($urandom));
                    write_reg(CFG_OWN_PORT, 48'h0);
                    write_reg(CFG_RX_BUF, 48'd0);
                    write_reg(CFG_VERIFY_SUM, 48'd1);
                end
                default: begin
                    write_reg(CFG_OWN_MAC, rand48());
                    write_reg(CFG_OWN_IP, 48'($urandom));
                    write_reg(CFG_OWN_PORT, 48'($urandom_range(0, 65535)));
                    write_reg(CFG_RX_BUF, ($urandom_range(0, 3) == 0) ? 48'd20 : 48'd2047);
                    write_reg(CFG_VERIFY_SUM, 48'($urandom_range(0, 1)));
                end
            endcase
            steady = (phase == 2);
            if (phase == 3) begin
                // runs past the frame cap, byte counter must saturate
                build_noise(FRAME_CAP + 40);
                send_frame();
            end
            phase_start = accepted;
            while (accepted - phase_start < PHASE_BYTES) begin
                r = $urandom_range(0, 19);
                if (r < 12) build_udp();
                else if (r < 17) build_arp();
                else build_noise($urandom_range(1, 40));
                send_frame();
            end
        end
        steady = 0;
        settle();
        $display("%0d bytes in %0d frames, %0d results checked", accepted, frames_sent, taken);
        $display("verdicts: %0d udp accepted, %0d arp requests, %0d dropped",
                 udp_accepts, arp_hits, drops);
        if (failures == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/uiarc_pkg.sv
rtl/core/uiarc_parser.sv
rtl/core/uiarc_queue.sv
rtl/core/uiarc_emitter.sv
rtl/core/udp_ipv4_arp_rx_classifier.sv
bench/testbench.sv
